// ===== src/sliding_window_max_2d_defines.svh =====
// ----------------------------------------------------------------------------
// Sliding window max 2D - assertion macros
// Shared property wrappers for the checker of the pooling block.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MAX_2D_DEFINES_SVH
`define SLIDING_WINDOW_MAX_2D_DEFINES_SVH

// Check a consequence in the same cycle, skipped while reset is high
`define SWM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the next cycle, skipped while reset is high
`define SWM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Check a consequence in the next cycle, also across reset
`define SWM_ASSERT_NEXT_NORST(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// Types, sizes and compare helpers of the sliding window max block.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

   // Block sizes
   localparam int MAX_WINDOW  = 8;
   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int PIXEL_BITS  = 32;

   // Register and field widths
   localparam int WSZ_BITS      = 4;
   localparam int DIM_BITS      = 11;
   localparam int CSR_DATA_BITS = 11;
   localparam int CSR_IDX_BITS  = 2;
   localparam int OUT_POS_BITS  = 10;

   // Derived widths
   localparam int K_BITS      = $clog2(MAX_WINDOW + 1);
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
   localparam int STORE_SLOTS = MAX_WINDOW - 1;
   localparam int STORE_BITS  = STORE_SLOTS * PIXEL_BITS;
   localparam int PAIR_CNT    = (MAX_WINDOW + 1) / 2;

   // Queue sizing
   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   typedef logic signed [PIXEL_BITS-1:0] pix_type;

   localparam pix_type PIX_MIN = {1'b1, {(PIXEL_BITS-1){1'b0}}};

   typedef pix_type win_type [MAX_WINDOW];
   typedef pix_type pair_type [PAIR_CNT];

   // Register indexes of the configuration port
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_WINDOW_SIZE  = 2'd0,
      CSR_FRAME_WIDTH  = 2'd1,
      CSR_FRAME_HEIGHT = 2'd2
   } csr_index_type;

   // One item as it moves from front to back and on to the result side
   typedef struct packed {
      logic signed [PIXEL_BITS-1:0] value;
      logic [COL_BITS-1:0]          addr;
      logic [OUT_POS_BITS-1:0]      row;
      logic [OUT_POS_BITS-1:0]      col;
      logic                         emit;
      logic                         last;
   } item_type;

   // Signed maximum of two pixels
   function automatic pix_type larger(input pix_type a, input pix_type b);
      return (b > a) ? b : a;
   endfunction

   // Mask entries at or above k, then take the first compare level
   function automatic pair_type pair_max(input win_type cand, input logic [K_BITS-1:0] k);
      win_type  m;
      pair_type p;
      for (int j = 0; j < MAX_WINDOW; j++) begin
         m[j] = (K_BITS'(j) < k) ? cand[j] : PIX_MIN;
      end
      for (int q = 0; q < PAIR_CNT; q++) begin
         if (2 * q + 1 < MAX_WINDOW) begin
            p[q] = larger(m[2*q], m[2*q+1]);
         end else begin
            p[q] = m[2*q];
         end
      end
      return p;
   endfunction

   // Remaining compare levels over the pair maxima
   function automatic pix_type reduce_max(input pair_type p);
      pix_type r;
      r = p[0];
      for (int q = 1; q < PAIR_CNT; q++) begin
         r = larger(r, p[q]);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/sliding_window_max_2d.sv =====
// ----------------------------------------------------------------------------
// sliding_window_max_2d
// Stride-1 k-by-k max pooling over a raster stream of signed pixels.
//
//   channel   dir  handshake               payload
//   req_      in   req_valid / req_ready   pixel_value
//   rsp_      out  rsp_valid / rsp_ready   window_max, out_row, out_col, frame_last
//   csr_      in   csr_write_en            csr_index, csr_wdata
//
// One pixel per cycle sustained while rsp_ready holds; the column store RAM takes
// one read and one write per cycle, set by its single read port and single
// write port. Each result passes the window and pair stages, the item queue,
// the read and compare registers and the result queue. Reset loads k=2 and a
// 1024x1024 frame; the column store needs no clearing pass, since every slot
// that a window uses is written earlier in the frame. A stalled result side
// backs up the result queue, then the item queue, and then req_ready falls.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_max_2d import swm_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [PIXEL_BITS-1:0] req_pixel_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [PIXEL_BITS-1:0] rsp_window_max,
   output logic [OUT_POS_BITS-1:0]      rsp_out_row,
   output logic [OUT_POS_BITS-1:0]      rsp_out_col,
   output logic                         rsp_frame_last,
   input  logic                         csr_write_en,
   input  logic [CSR_IDX_BITS-1:0]      csr_index,
   input  logic [CSR_DATA_BITS-1:0]     csr_wdata
);

   logic [K_BITS-1:0]        win_k;
   logic                     q_push;
   item_type                 q_push_item;
   logic                     q_full;
   logic                     q_pop;
   logic                     q_valid;
   item_type                 q_item;
   logic [FIFO_CNT_BITS-1:0] q_count;
   item_type                 rsp_item;

   // Front: configuration, position and horizontal max
   swm_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_value (req_pixel_value),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .win_k           (win_k),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_item          (q_push_item)
   );

   // Item queue between front and back
   swm_fifo u_item_q (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_push_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_item  (q_item),
      .count      (q_count)
   );

   // Back: column store, vertical max and results
   swm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .win_k     (win_k),
      .q_valid   (q_valid && (q_count != '0)),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .out_valid (rsp_valid),
      .out_item  (rsp_item),
      .out_ready (rsp_ready)
   );

   assign rsp_window_max = rsp_item.value;
   assign rsp_out_row    = rsp_item.row;
   assign rsp_out_col    = rsp_item.col;
   assign rsp_frame_last = rsp_item.last;

endmodule

`default_nettype wire

// ===== src/swm_ram.sv =====
// ----------------------------------------------------------------------------
// swm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and read the old contents on a collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/swm_fifo.sv =====
// ----------------------------------------------------------------------------
// swm_fifo
// Short register queue of items with occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_fifo import swm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  item_type                 push_item,
   output logic                     full,
   input  logic                     pop,
   output logic                     head_valid,
   output item_type                 head_item,
   output logic [FIFO_CNT_BITS-1:0] count
);

   item_type                 mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;
   logic                     do_push;
   logic                     do_pop;

   assign full       = (count_ff == FIFO_CNT_BITS'(FIFO_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];
   assign count      = count_ff;
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0
                   : wr_ptr_ff + FIFO_PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0
                   : rd_ptr_ff + FIFO_PTR_BITS'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + FIFO_CNT_BITS'(1);
         2'b01:   count_in = count_ff - FIFO_CNT_BITS'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== src/swm_front.sv =====
// ----------------------------------------------------------------------------
// swm_front
// Configuration registers, raster position, row window and horizontal max.
// Drops pixels that do not reach a full window width and queues the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_front import swm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [PIXEL_BITS-1:0] req_pixel_value,
   input  logic                      csr_write_en,
   input  logic [CSR_IDX_BITS-1:0]   csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output logic [K_BITS-1:0]         win_k,
   input  logic                      q_full,
   output logic                      q_push,
   output item_type                  q_item
);

   logic [WSZ_BITS-1:0] wsz_ff, wsz_in;
   logic [DIM_BITS-1:0] fw_ff, fw_in;
   logic [DIM_BITS-1:0] fh_ff, fh_in;
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   win_type             window_ff, window_in;
   logic                a_valid_ff, a_valid_in;
   logic                a_active_ff, a_active_in;
   item_type            a_item_ff, a_item_in;
   logic                b_valid_ff, b_valid_in;
   pair_type            b_pair_ff, b_pair_in;
   item_type            b_item_ff, b_item_in;

   logic [K_BITS-1:0]   k;
   logic [DIM_BITS-1:0] w;
   logic [DIM_BITS-1:0] h;
   logic [DIM_BITS-1:0] x1;
   logic [DIM_BITS-1:0] y1;
   logic                accept;
   logic                a_move;
   logic                b_move;
   logic                b_free;

   // Saturate the configuration into its legal range
   assign k = (wsz_ff == '0) ? K_BITS'(1)
            : (int'(wsz_ff) > MAX_WINDOW) ? K_BITS'(MAX_WINDOW) : K_BITS'(wsz_ff);
   assign w = (fw_ff == '0) ? DIM_BITS'(1)
            : (int'(fw_ff) > MAX_WIDTH) ? DIM_BITS'(MAX_WIDTH) : fw_ff;
   assign h = (fh_ff == '0) ? DIM_BITS'(1)
            : (int'(fh_ff) > MAX_HEIGHT) ? DIM_BITS'(MAX_HEIGHT) : fh_ff;
   assign win_k = k;

   // Pipeline handshake: window stage, pair stage, queue
   assign b_move    = b_valid_ff && !q_full;
   assign b_free    = !b_valid_ff || b_move;
   assign a_move    = a_valid_ff && (!a_active_ff || b_free);
   assign req_ready = !a_valid_ff || a_move;
   assign accept    = req_valid && req_ready;

   assign x1 = DIM_BITS'(col_ff) + DIM_BITS'(1);
   assign y1 = DIM_BITS'(row_ff) + DIM_BITS'(1);

   always_comb begin
      wsz_in      = wsz_ff;
      fw_in       = fw_ff;
      fh_in       = fh_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      window_in   = window_ff;
      a_valid_in  = a_valid_ff;
      a_active_in = a_active_ff;
      a_item_in   = a_item_ff;
      b_valid_in  = b_valid_ff;
      b_pair_in   = b_pair_ff;
      b_item_in   = b_item_ff;

      // Shift the row window and classify the pixel
      if (accept) begin
         window_in[0] = req_pixel_value;
         for (int i = 1; i < MAX_WINDOW; i++) begin
            window_in[i] = window_ff[i-1];
         end
         a_active_in     = (x1 >= DIM_BITS'(k));
         a_item_in.value = req_pixel_value;
         a_item_in.addr  = col_ff;
         a_item_in.row   = OUT_POS_BITS'(y1 - DIM_BITS'(k));
         a_item_in.col   = OUT_POS_BITS'(x1 - DIM_BITS'(k));
         a_item_in.emit  = (x1 >= DIM_BITS'(k)) && (y1 >= DIM_BITS'(k));
         a_item_in.last  = (x1 == w) && (y1 == h);
         if (x1 >= w) begin
            col_in = '0;
            row_in = (y1 >= h) ? '0 : ROW_BITS'(y1);
         end else begin
            col_in = COL_BITS'(x1);
         end
      end

      // Hold the window stage until it moves on
      if (accept) begin
         a_valid_in = 1'b1;
      end else if (a_move) begin
         a_valid_in = 1'b0;
      end

      // Load the pair stage with active pixels only
      if (a_move && a_active_ff) begin
         b_valid_in = 1'b1;
         b_pair_in  = pair_max(window_ff, k);
         b_item_in  = a_item_ff;
      end else if (b_move) begin
         b_valid_in = 1'b0;
      end

      // Writes to the known registers restart the frame
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_WINDOW_SIZE: begin
               wsz_in = csr_wdata[WSZ_BITS-1:0];
               col_in = '0;
               row_in = '0;
            end
            CSR_FRAME_WIDTH: begin
               fw_in  = csr_wdata[DIM_BITS-1:0];
               col_in = '0;
               row_in = '0;
            end
            CSR_FRAME_HEIGHT: begin
               fh_in  = csr_wdata[DIM_BITS-1:0];
               col_in = '0;
               row_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wsz_ff     <= WSZ_BITS'(2);
         fw_ff      <= DIM_BITS'(MAX_WIDTH);
         fh_ff      <= DIM_BITS'(MAX_HEIGHT);
         col_ff     <= '0;
         row_ff     <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         wsz_ff     <= wsz_in;
         fw_ff      <= fw_in;
         fh_ff      <= fh_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff   <= window_in;
      a_active_ff <= a_active_in;
      a_item_ff   <= a_item_in;
      b_pair_ff   <= b_pair_in;
      b_item_ff   <= b_item_in;
   end

   // Finish the horizontal max on the way into the queue
   always_comb begin
      q_item       = b_item_ff;
      q_item.value = reduce_max(b_pair_ff);
   end
   assign q_push = b_move;

endmodule

`default_nettype wire

// ===== src/swm_back.sv =====
// ----------------------------------------------------------------------------
// swm_back
// Column store read-modify-write, vertical max and result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_back import swm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [K_BITS-1:0] win_k,
   input  logic              q_valid,
   input  item_type          q_item,
   output logic              q_pop,
   output logic              out_valid,
   output item_type          out_item,
   input  logic              out_ready
);

   localparam int SUM_BITS = FIFO_CNT_BITS + 1;

   logic                     r_valid_ff, r_valid_in;
   item_type                 r_item_ff, r_item_in;
   logic                     fwd_hit_ff, fwd_hit_in;
   logic [STORE_BITS-1:0]    fwd_word_ff, fwd_word_in;
   logic                     e_valid_ff, e_valid_in;
   item_type                 e_item_ff, e_item_in;
   pair_type                 e_pair_ff, e_pair_in;

   logic [STORE_BITS-1:0]    rd_data;
   logic [STORE_BITS-1:0]    store_word;
   logic [STORE_BITS-1:0]    new_word;
   pix_type                  old_slot [STORE_SLOTS];
   win_type                  cand;
   logic                     store_wr;
   logic [SUM_BITS-1:0]      in_flight;
   logic [FIFO_CNT_BITS-1:0] out_count;
   logic                     out_full;
   logic                     out_push;
   item_type                 out_push_item;

   // Pop only when the result queue has room for everything in flight
   assign in_flight = SUM_BITS'(out_count) + SUM_BITS'(r_valid_ff) + SUM_BITS'(e_valid_ff);
   assign q_pop     = q_valid && (in_flight < SUM_BITS'(FIFO_DEPTH));
   assign store_wr  = r_valid_ff && (win_k >= K_BITS'(2));

   // Take the word just written when the read hit the same column
   assign store_word = fwd_hit_ff ? fwd_word_ff : rd_data;

   always_comb begin
      for (int i = 0; i < STORE_SLOTS; i++) begin
         old_slot[i] = store_word[i*PIXEL_BITS +: PIXEL_BITS];
      end
      // Push the new horizontal max in front, age the rest
      new_word[0 +: PIXEL_BITS] = r_item_ff.value;
      for (int i = 1; i < STORE_SLOTS; i++) begin
         new_word[i*PIXEL_BITS +: PIXEL_BITS] = old_slot[i-1];
      end
      cand[0] = r_item_ff.value;
      for (int j = 1; j < MAX_WINDOW; j++) begin
         cand[j] = old_slot[j-1];
      end
   end

   always_comb begin
      r_valid_in  = q_pop;
      r_item_in   = q_item;
      fwd_hit_in  = q_pop && store_wr && (q_item.addr == r_item_ff.addr);
      fwd_word_in = new_word;
      e_valid_in  = r_valid_ff && r_item_ff.emit;
      e_item_in   = r_item_ff;
      e_pair_in   = pair_max(cand, win_k);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
         fwd_hit_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         r_valid_ff <= r_valid_in;
         fwd_hit_ff <= fwd_hit_in;
         e_valid_ff <= e_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r_item_ff   <= r_item_in;
      fwd_word_ff <= fwd_word_in;
      e_item_ff   <= e_item_in;
      e_pair_ff   <= e_pair_in;
   end

   // Column store: one word per column, the MAX_WINDOW-1 newest horizontal maxima
   swm_ram #(
      .WIDTH (STORE_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (r_item_ff.addr),
      .wr_data (new_word),
      .rd_en   (q_pop),
      .rd_addr (q_item.addr),
      .rd_data (rd_data)
   );

   // Finish the vertical max on the way into the result queue
   always_comb begin
      out_push_item       = e_item_ff;
      out_push_item.value = reduce_max(e_pair_ff);
   end
   assign out_push = e_valid_ff && !out_full;

   swm_fifo u_result_q (
      .clock      (clock),
      .reset      (reset),
      .push       (out_push),
      .push_item  (out_push_item),
      .full       (out_full),
      .pop        (out_ready),
      .head_valid (out_valid),
      .head_item  (out_item),
      .count      (out_count)
   );

endmodule

`default_nettype wire

// ===== src/swm_check.sv =====
// ----------------------------------------------------------------------------
// swm_check
// Port-level checks of the sliding window max block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_max_2d_defines.svh"

module swm_check import swm_pkg::*; (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic signed [PIXEL_BITS-1:0] req_pixel_value,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [PIXEL_BITS-1:0] rsp_window_max,
   input logic [OUT_POS_BITS-1:0]      rsp_out_row,
   input logic [OUT_POS_BITS-1:0]      rsp_out_col,
   input logic                         rsp_frame_last,
   input logic                         csr_write_en,
   input logic [CSR_IDX_BITS-1:0]      csr_index,
   input logic [CSR_DATA_BITS-1:0]     csr_wdata
);

   // A stalled result stays offered
   `SWM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result withdrawn while stalled")

   // A stalled result keeps its payload
   `SWM_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_window_max) && $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_frame_last), "result changed while stalled")

   // Reset leaves no result pending
   `SWM_ASSERT_NEXT_NORST(a_reset_empty, clock, reset, !rsp_valid, "result pending after reset")

   // The result after a frame's last one opens the next frame
   `SWM_ASSERT_NEXT(a_frame_wrap, clock, reset, rsp_valid && rsp_ready && rsp_frame_last, !rsp_valid || (rsp_out_row == '0 && rsp_out_col == '0), "next frame does not start at the origin")

endmodule

bind sliding_window_max_2d swm_check u_swm_check (.*);

`default_nettype wire

// ===== tb/sv/sliding_window_max_2d_scoreboard.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_max_2d_scoreboard
// Watches the pixel, result and register ports of the pooling block, keeps
// its own copy of the row window, line store and frame position, predicts
// every pooled window and checks each result field by field, in order.
// ----------------------------------------------------------------------------

module sliding_window_max_2d_scoreboard import swm_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  pix_type                      req_pixel_value,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  pix_type                      rsp_window_max,
   input  logic [OUT_POS_BITS-1:0]      rsp_out_row,
   input  logic [OUT_POS_BITS-1:0]      rsp_out_col,
   input  logic                         rsp_frame_last,
   input  logic                         csr_write_en,
   input  logic [CSR_IDX_BITS-1:0]      csr_index,
   input  logic [CSR_DATA_BITS-1:0]     csr_wdata,
   output int                           pending_results,
   output int                           mismatch_count
);

   localparam logic [WSZ_BITS-1:0] RESET_WINDOW = 2;
   localparam logic [DIM_BITS-1:0] RESET_WIDTH  = 1024;
   localparam logic [DIM_BITS-1:0] RESET_HEIGHT = 1024;

   typedef struct {
      pix_type                 window_max;
      logic [OUT_POS_BITS-1:0] row;
      logic [OUT_POS_BITS-1:0] col;
      logic                    last;
   } pooled_window_type;

   // Register copies, as written (saturation happens at use)
   logic [WSZ_BITS-1:0] window_reg;
   logic [DIM_BITS-1:0] width_reg;
   logic [DIM_BITS-1:0] height_reg;

   // Last pixels received, newest first
   pix_type row_taps [MAX_WINDOW];
   // Per column, the last k-1 horizontal maxima, newest first
   pix_type line_hist [MAX_WIDTH][STORE_SLOTS];
   int      col_pos;
   int      row_pos;

   pooled_window_type pending_windows [$];

   function automatic int clamp_reg(input int v, input int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Advance the pooling state by one pixel, queue the window it completes
   task automatic pool_pixel(input pix_type px);
      int                k;
      int                w;
      int                h;
      int                x;
      int                y;
      pix_type           hmax;
      pix_type           vmax;
      pooled_window_type win;
      k = clamp_reg(window_reg, MAX_WINDOW);
      w = clamp_reg(width_reg, MAX_WIDTH);
      h = clamp_reg(height_reg, MAX_HEIGHT);
      x = (col_pos >= w) ? 0 : col_pos;
      y = (row_pos >= h) ? 0 : row_pos;

      for (int i = MAX_WINDOW - 1; i > 0; i--) row_taps[i] = row_taps[i-1];
      row_taps[0] = px;

      if (x + 1 >= k) begin
         hmax = row_taps[0];
         for (int i = 1; i < k; i++) begin
            if (row_taps[i] > hmax) hmax = row_taps[i];
         end
         if (y + 1 >= k) begin
            vmax = hmax;
            for (int i = 0; i < k - 1; i++) begin
               if (line_hist[x][i] > vmax) vmax = line_hist[x][i];
            end
            win.window_max = vmax;
            win.row        = OUT_POS_BITS'(y + 1 - k);
            win.col        = OUT_POS_BITS'(x + 1 - k);
            win.last       = (x + 1 == w) && (y + 1 == h);
            pending_windows.insert(pending_windows.size(), win);
         end
         // shift this column's history, newest horizontal max in front
         if (k >= 2) begin
            for (int i = k - 2; i > 0; i--) line_hist[x][i] = line_hist[x][i-1];
            line_hist[x][0] = hmax;
         end
      end

      x++;
      if (x >= w) begin
         x = 0;
         y++;
         if (y >= h) y = 0;
      end
      col_pos = x;
      row_pos = y;
   endtask

   always @(posedge clock) begin
      pooled_window_type want;
      if (reset) begin
         window_reg = RESET_WINDOW;
         width_reg  = RESET_WIDTH;
         height_reg = RESET_HEIGHT;
         for (int i = 0; i < MAX_WINDOW; i++) row_taps[i] = '0;
         for (int c = 0; c < MAX_WIDTH; c++) begin
            for (int s = 0; s < STORE_SLOTS; s++) line_hist[c][s] = '0;
         end
         col_pos = 0;
         row_pos = 0;
         pending_windows.delete();
      end else begin
         // register write: any known register restarts the frame
         if (csr_write_en) begin
            case (csr_index)
               CSR_WINDOW_SIZE: begin
                  window_reg = csr_wdata[WSZ_BITS-1:0];
                  col_pos = 0;
                  row_pos = 0;
               end
               CSR_FRAME_WIDTH: begin
                  width_reg = csr_wdata[DIM_BITS-1:0];
                  col_pos = 0;
                  row_pos = 0;
               end
               CSR_FRAME_HEIGHT: begin
                  height_reg = csr_wdata[DIM_BITS-1:0];
                  col_pos = 0;
                  row_pos = 0;
               end
               default: ;
            endcase
         end

         if (req_valid && req_ready) pool_pixel(req_pixel_value);

         // compare each result with the oldest predicted window
         if (rsp_valid && rsp_ready) begin
            if (pending_windows.size() == 0) begin
               $display("%0t: result with nothing pending: max %0d row %0d col %0d last %0b",
                        $time, rsp_window_max, rsp_out_row, rsp_out_col, rsp_frame_last);
               mismatch_count++;
            end else begin
               want = pending_windows.pop_front();
               if (rsp_window_max !== want.window_max) begin
                  $display("%0t: window_max expected %0d, got %0d",
                           $time, want.window_max, rsp_window_max);
                  mismatch_count++;
               end
               if (rsp_out_row !== want.row) begin
                  $display("%0t: out_row expected %0d, got %0d", $time, want.row, rsp_out_row);
                  mismatch_count++;
               end
               if (rsp_out_col !== want.col) begin
                  $display("%0t: out_col expected %0d, got %0d", $time, want.col, rsp_out_col);
                  mismatch_count++;
               end
               if (rsp_frame_last !== want.last) begin
                  $display("%0t: frame_last expected %0b, got %0b",
                           $time, want.last, rsp_frame_last);
                  mismatch_count++;
               end
            end
         end
      end
      pending_results = pending_windows.size();
   end

endmodule

// ===== tb/sv/tb_sliding_window_max_2d.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_max_2d
// Drives pixel frames into the max pooling block under several window and
// frame settings, with random idling on both sides, a long result stall and
// a full-width row; the scoreboard predicts and checks every result.
// ----------------------------------------------------------------------------

module tb_sliding_window_max_2d;
   import swm_pkg::*;

   localparam int      WATCHDOG_LIMIT = 3000;
   localparam int      DRAIN_CYCLES   = 20;
   localparam int      RANDOM_ITEMS   = 400;
   localparam int      HOLD_CYCLES    = 300;
   localparam int      PHASE_CAP      = 100;
   localparam pix_type PIX_MAX        = {1'b0, {(PIXEL_BITS-1){1'b1}}};
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_INDEX = 2'd3;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   pix_type                  req_pixel_value;
   logic                     rsp_valid;
   logic                     rsp_ready;
   pix_type                  rsp_window_max;
   logic [OUT_POS_BITS-1:0]  rsp_out_row;
   logic [OUT_POS_BITS-1:0]  rsp_out_col;
   logic                     rsp_frame_last;
   logic                     csr_write_en;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;
   int                       pending_results;
   int                       mismatch_count;

   int send_idle_pct;
   int stall_pct;
   int hold_left;
   int quiet_cycles;

   sliding_window_max_2d DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_value (req_pixel_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_window_max  (rsp_window_max),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_frame_last  (rsp_frame_last),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   sliding_window_max_2d_scoreboard u_scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_value (req_pixel_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_window_max  (rsp_window_max),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_frame_last  (rsp_frame_last),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .pending_results (pending_results),
      .mismatch_count  (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Result side: long hold-off first, otherwise random stalls
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // End the run when nothing moves for too long
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb_sliding_window_max_2d: FAIL");
            $finish;
         end
      end
   end

   function automatic pix_type random_pixel();
      case ($urandom_range(9))
         0:       return PIX_MIN;
         1:       return PIX_MAX;
         2, 3:    return pix_type'($urandom_range(8)) - 4;
         default: return pix_type'($urandom);
      endcase
   endfunction

   function automatic int dim_clamp(input logic [CSR_DATA_BITS-1:0] v, input int hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Change idle rates at a rising edge so the result side sees them cleanly
   task automatic set_idle(input int sender_pct, input int receiver_pct);
      @(posedge clock);
      send_idle_pct = sender_pct;
      stall_pct     = receiver_pct;
      @(negedge clock);
   endtask

   // Offer one pixel, with random idle cycles ahead of it; hold until accepted
   task automatic send_pixel(input pix_type px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_value <= px;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Stop offering pixels until every predicted window has come out
   task automatic pause_for_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_results != 0);
   endtask

   // Drain results, then give the pipeline time to finish pixels with no result
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(negedge clock);
   endtask

   task automatic set_window(input logic [CSR_DATA_BITS-1:0] k_raw,
                             input logic [CSR_DATA_BITS-1:0] w_raw,
                             input logic [CSR_DATA_BITS-1:0] h_raw);
      write_csr(CSR_WINDOW_SIZE, k_raw);
      write_csr(CSR_FRAME_WIDTH, w_raw);
      write_csr(CSR_FRAME_HEIGHT, h_raw);
      if ($urandom_range(3) == 0) write_csr(CSR_SPARE_INDEX, CSR_DATA_BITS'($urandom));
      csr_write_en <= 1'b0;
   endtask

   initial begin
      int                       sent;
      int                       phase;
      int                       n;
      int                       kmax;
      int                       wc;
      int                       hc;
      logic [CSR_DATA_BITS-1:0] k_raw;
      logic [CSR_DATA_BITS-1:0] w_raw;
      logic [CSR_DATA_BITS-1:0] h_raw;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_pixel_value = '0;
      csr_write_en    = 1'b0;
      csr_index       = CSR_WINDOW_SIZE;
      csr_wdata       = '0;
      send_idle_pct   = 0;
      stall_pct       = 0;
      hold_left       = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // A few pixels at the reset settings: row 0 never completes a window
      send_pixel(PIX_MIN);
      send_pixel(PIX_MAX);
      send_pixel('0);

      // 2x2 windows over a 3x3 frame with extreme pixels
      drain_results();
      set_window(2, 3, 3);
      send_pixel(PIX_MIN);
      send_pixel(PIX_MAX);
      send_pixel(-1);
      send_pixel('0);
      send_pixel(1);
      send_pixel(PIX_MIN);
      send_pixel(pix_type'(32'h5555_5555));
      send_pixel(pix_type'(32'hAAAA_AAAA));
      send_pixel(-2);

      // Window wider than the frame: nothing comes out
      drain_results();
      set_window(4, 3, 5);
      repeat (4) send_pixel(random_pixel());

      // Window as large as the whole frame: one result, flagged last
      drain_results();
      set_window(3, 3, 3);
      repeat (9) send_pixel(random_pixel());

      // Full-width row
      drain_results();
      set_window(1, CSR_DATA_BITS'(MAX_WIDTH), 1);
      repeat (MAX_WIDTH) send_pixel(random_pixel());

      // Stall the result side long enough to back up the input
      drain_results();
      set_window(1, 8, 8);
      @(posedge clock);
      hold_left = HOLD_CYCLES;
      @(negedge clock);
      repeat (100) send_pixel(random_pixel());
      pause_for_results();
      repeat (40) send_pixel(random_pixel());

      // Random frames, mostly well-formed settings, under rotating idle rates
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         case (phase % 4)
            0:       set_idle(0, 0);
            1:       set_idle(73, 0);
            2:       set_idle(0, 73);
            default: set_idle(14, 14);
         endcase
         if ($urandom_range(4) == 0) begin
            k_raw = CSR_DATA_BITS'($urandom_range(0, 2047));
            w_raw = $urandom_range(1) ? '0 : CSR_DATA_BITS'($urandom_range(0, 2047));
            h_raw = $urandom_range(1) ? CSR_DATA_BITS'($urandom_range(0, 2047))
                                      : CSR_DATA_BITS'($urandom_range(0, 15));
         end else begin
            w_raw = CSR_DATA_BITS'($urandom_range(1, 12));
            h_raw = CSR_DATA_BITS'($urandom_range(1, 12));
            kmax  = MAX_WINDOW;
            if (w_raw < kmax) kmax = w_raw;
            if (h_raw < kmax) kmax = h_raw;
            k_raw = {7'($urandom), 4'($urandom_range(1, kmax))};
         end
         wc = dim_clamp(w_raw, MAX_WIDTH);
         hc = dim_clamp(h_raw, MAX_HEIGHT);
         n  = $urandom_range(1, 3) * wc * hc + $urandom_range(0, wc * hc - 1);
         if (n > PHASE_CAP) n = PHASE_CAP;

         drain_results();
         set_window(k_raw, w_raw, h_raw);
         for (int i = 0; i < n; i++) begin
            if (i == n / 2 && $urandom_range(3) == 0) pause_for_results();
            send_pixel(random_pixel());
         end
         sent += n;
         phase++;
      end

      drain_results();
      if (mismatch_count == 0) begin
         $display("tb_sliding_window_max_2d: PASS");
      end else begin
         $display("tb_sliding_window_max_2d: FAIL");
      end
      $finish;
   end

endmodule
